FILE: hdl/lrut_pkg.sv
// Shared types and constants for the LRU replacement tracker.
// Holds the command codes and the transfer structs; depends on nothing else.
`default_nettype none

package lrut_pkg;

    // Block index as carried on the ports
    localparam int BLK_W     = 4;
    localparam int BLK_RANGE = 16;

    typedef logic [BLK_W-1:0] t_blk;
    typedef logic [1:0]       t_cmd;

    // Command codes
    localparam t_cmd CMD_ACCESS  = 2'd0;
    localparam t_cmd CMD_REPLACE = 2'd1;
    localparam t_cmd CMD_CLEAR   = 2'd2;

    // Input transfer
    typedef struct packed {
        t_cmd command;
        t_blk block_index;
    } t_lrut_in;

    // Result transfer
    typedef struct packed {
        t_blk victim_index;
        logic victim_found;
    } t_lrut_out;

endpackage

`default_nettype wire

FILE: hdl/lru_replacement_tracker_unit.sv
// LRU replacement tracker: recency list in a single-port-write memory,
// walked by a small sequencer. Depends on lrut_pkg.
//
//   channel   | direction | handshake          | payload
//   ----------+-----------+--------------------+-------------------------------
//   command   | in        | start, busy        | i_item  (command, block_index)
//   result    | out       | o_strobe (1 cycle) | o_result (victim_index, found)
//
// Sequencing: an access to an unlisted block, a clear and a replace on an
// empty list are handled at acceptance and leave the block ready. An access
// to a listed block does one memory read per cycle to find it, then one read
// and one write per cycle to close the gap, then one write to append; nothing
// moves if it is already most recent. A replace reads the victim at the head,
// then closes the gap the same way. The one read port and write port set this order.
// Reset is synchronous and active low; it empties the list. The result is
// shown for one cycle and the receiver cannot hold it off.
`default_nettype none

module lru_replacement_tracker_unit
    import lrut_pkg::*;
#(
    parameter int NUM_BLOCKS = 16
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      start,
    output logic           busy,
    input  wire t_lrut_in  i_item,
    output logic           o_strobe,
    output t_lrut_out      o_result
);

    localparam int AW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int CW = $clog2(NUM_BLOCKS + 1);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SEARCH = 5'b00010,
        S_VICTIM = 5'b00100,
        S_SHIFT  = 5'b01000,
        S_APPEND = 5'b10000
    } t_state;

    t_state                r_state, n_state;
    logic [CW-1:0]         r_count, n_count;
    logic [BLK_RANGE-1:0]  r_mark, n_mark;
    logic [AW-1:0]         r_pos, n_pos;
    t_blk                  r_blk, n_blk;
    logic                  r_replace, n_replace;
    logic                  r_strobe, n_strobe;
    t_lrut_out             r_result, n_result;

    // Recency list memory, least recent at address 0
    t_blk                  r_mem [NUM_BLOCKS];
    t_blk                  r_rdata;
    logic                  mem_we, mem_re;
    logic [AW-1:0]         mem_waddr, mem_raddr;
    t_blk                  mem_wdata;

    logic                  accept;
    logic                  blk_ok;
    logic [CW-1:0]         pos_next;
    logic [AW-1:0]         pos_inc;

    assign accept   = start && !busy;
    assign blk_ok   = ({28'd0, i_item.block_index} < 32'(NUM_BLOCKS));
    assign pos_next = CW'(r_pos) + CW'(1);
    assign pos_inc  = r_pos + AW'(1);

    // Sequencer
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_mark    = r_mark;
        n_pos     = r_pos;
        n_blk     = r_blk;
        n_replace = r_replace;
        n_strobe  = 1'b0;
        n_result  = r_result;
        mem_we    = 1'b0;
        mem_waddr = r_pos - AW'(1);
        mem_wdata = r_rdata;
        mem_re    = 1'b0;
        mem_raddr = pos_inc;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_item.command)
                        CMD_ACCESS: begin
                            if (blk_ok) begin
                                n_blk = i_item.block_index;
                                if (r_mark[i_item.block_index]) begin
                                    // listed: find it first
                                    mem_re    = 1'b1;
                                    mem_raddr = '0;
                                    n_pos     = '0;
                                    n_replace = 1'b0;
                                    n_state   = S_SEARCH;
                                end else if (r_count < CW'(NUM_BLOCKS)) begin
                                    // not listed: append at once
                                    mem_we    = 1'b1;
                                    mem_waddr = r_count[AW-1:0];
                                    mem_wdata = i_item.block_index;
                                    n_count   = r_count + CW'(1);
                                    n_mark[i_item.block_index] = 1'b1;
                                end
                            end
                        end
                        CMD_REPLACE: begin
                            if (r_count == '0) begin
                                n_strobe = 1'b1;
                                n_result = '0;
                            end else begin
                                mem_re    = 1'b1;
                                mem_raddr = '0;
                                n_pos     = '0;
                                n_replace = 1'b1;
                                n_state   = S_VICTIM;
                            end
                        end
                        CMD_CLEAR: begin
                            n_mark  = '0;
                            n_count = '0;
                        end
                        default: ;
                    endcase
                end
            end
            S_SEARCH: begin
                if (r_rdata == r_blk) begin
                    if (pos_next < r_count) begin
                        mem_re  = 1'b1;
                        n_pos   = pos_inc;
                        n_state = S_SHIFT;
                    end else begin
                        // already most recent: nothing moves
                        n_state = S_IDLE;
                    end
                end else if (pos_next < r_count) begin
                    mem_re = 1'b1;
                    n_pos  = pos_inc;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_VICTIM: begin
                n_strobe                    = 1'b1;
                n_result.victim_index       = r_rdata;
                n_result.victim_found       = 1'b1;
                n_mark[r_rdata]             = 1'b0;
                if (pos_next < r_count) begin
                    mem_re  = 1'b1;
                    n_pos   = pos_inc;
                    n_state = S_SHIFT;
                end else begin
                    n_count = r_count - CW'(1);
                    n_state = S_IDLE;
                end
            end
            S_SHIFT: begin
                // move the entry just read one place toward the head
                mem_we = 1'b1;
                if (pos_next < r_count) begin
                    mem_re = 1'b1;
                    n_pos  = pos_inc;
                end else if (r_replace) begin
                    n_count = r_count - CW'(1);
                    n_state = S_IDLE;
                end else begin
                    n_state = S_APPEND;
                end
            end
            S_APPEND: begin
                mem_we    = 1'b1;
                mem_waddr = AW'(r_count - CW'(1));
                mem_wdata = r_blk;
                n_state   = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_mark   <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_mark   <= n_mark;
            r_strobe <= n_strobe;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_pos     <= n_pos;
        r_blk     <= n_blk;
        r_replace <= n_replace;
        r_result  <= n_result;
    end

    // Memory: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_raddr];
        end
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_result;

    // Checks
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(NUM_BLOCKS))
        else $error("list count beyond depth");

    a_marks_match_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (32'(r_count) == $countones(r_mark)))
        else $error("listed marks disagree with list count");

    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_result.victim_found) |-> (o_result.victim_index == '0))
        else $error("empty replace returned a nonzero index");

    a_busy_needs_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!busy && !start) |=> !busy)
        else $error("busy raised without a transfer");

    a_strobe_needs_replace: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && !(start && i_item.command == CMD_REPLACE)) |=> !o_strobe)
        else $error("result without a replace request");

endmodule

`default_nettype wire
